[hdl/lifdr_pkg.sv]
package lifdr_pkg;

  localparam int POT_W     = 24;
  localparam int CUR_W     = 16;
  localparam int FACTOR_W  = 16;
  localparam int REFR_W    = 8;
  localparam int DELAY_W   = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;

  typedef logic signed [POT_W-1:0] pot_t;
  typedef logic signed [CUR_W-1:0] cur_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DECAY_FACTOR     = 3'd0,
    REG_DRIVE_GAIN       = 3'd1,
    REG_FIRE_THRESHOLD   = 3'd2,
    REG_RESET_POTENTIAL  = 3'd3,
    REG_REFRACTORY_TICKS = 3'd4,
    REG_DELAY_TICKS      = 3'd5,
    REG_SYNAPTIC_WEIGHT  = 3'd6,
    REG_INTEGRATE_ENABLE = 3'd7
  } reg_idx_t;

  localparam logic [FACTOR_W-1:0] DECAY_FACTOR_RST     = 16'd64881;
  localparam logic [FACTOR_W-1:0] DRIVE_GAIN_RST       = 16'd668;
  localparam pot_t                FIRE_THRESHOLD_RST   = -24'sd14336;
  localparam pot_t                RESET_POTENTIAL_RST  = -24'sd17920;
  localparam logic [REFR_W-1:0]   REFRACTORY_TICKS_RST = 8'd4;
  localparam logic [DELAY_W-1:0]  DELAY_TICKS_RST      = 4'd15;
  localparam pot_t                SYNAPTIC_WEIGHT_RST  = 24'sd26;

  localparam pot_t POT_MAX = 24'sh7FFFFF;
  localparam pot_t POT_MIN = 24'sh800000;

  // Clamp a 25-bit sum to the 24-bit potential range.
  function automatic pot_t sat_pot(input logic signed [POT_W:0] v);
    pot_t r;
    if (v[POT_W] != v[POT_W-1]) begin
      r = v[POT_W] ? POT_MIN : POT_MAX;
    end else begin
      r = v[POT_W-1:0];
    end
    return r;
  endfunction

endpackage

[hdl/lifdr_tick_if.sv]
interface lifdr_tick_if import lifdr_pkg::*; ();
  logic valid;
  logic ready;
  cur_t input_current;
  logic presyn_spike;

  modport source (output valid, output input_current, output presyn_spike, input ready);
  modport sink   (input valid, input input_current, input presyn_spike, output ready);
endinterface

[hdl/lifdr_result_if.sv]
interface lifdr_result_if import lifdr_pkg::*; ();
  logic valid;
  logic ready;
  logic spike_out;
  pot_t membrane_potential;

  modport source (output valid, output spike_out, output membrane_potential, input ready);
  modport sink   (input valid, input spike_out, input membrane_potential, output ready);
endinterface

[hdl/lifdr_cfg_if.sv]
interface lifdr_cfg_if import lifdr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/lif_neuron_with_delay_ring_core.sv]
// Leaky integrate-and-fire neuron with a synaptic delay ring.
// A request is captured in the input register, and its result in the result register.
// Throughput: one request per cycle unless results stall; each tick's multiply-add on
// the potential and the read of the current ring slot fit in the single compute stage.
// Reset (rst, synchronous): configuration returns to its defaults, the potential to
// the default reset potential, counters and pointer to zero; ring slots read as zero.
module lif_neuron_with_delay_ring_core import lifdr_pkg::*; #(
  parameter int RING_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  lifdr_tick_if.sink        tick,
  lifdr_result_if.source    result,
  lifdr_cfg_if.sink         cfg
);

  localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  // Configuration registers.
  logic [FACTOR_W-1:0] decay_factor;
  logic [FACTOR_W-1:0] drive_gain;
  pot_t                fire_threshold;
  pot_t                reset_potential;
  logic [REFR_W-1:0]   refractory_ticks;
  logic [DELAY_W-1:0]  delay_ticks;
  pot_t                synaptic_weight;
  logic                integrate_enable;

  // Neuron state.
  pot_t                  potential;
  logic [REFR_W-1:0]     refr_cnt;
  logic [PTR_W-1:0]      ptr;
  logic [RING_DEPTH-1:0] slot_valid;
  pot_t                  slot_mem [RING_DEPTH];
  pot_t                  slot_rd;
  logic                  byp_hit;

  // Input register and result register.
  logic s1_valid;
  cur_t cur_q;
  logic pre_q;
  logic out_valid;
  logic out_spike;
  pot_t out_pot;

  logic s1_adv;
  logic proc;

  assign cfg.ready    = 1'b1;
  assign s1_adv       = !out_valid || result.ready;
  assign proc         = s1_valid && s1_adv;
  assign tick.ready   = !s1_valid || s1_adv;

  assign result.valid              = out_valid;
  assign result.spike_out          = out_spike;
  assign result.membrane_potential = out_pot;

  always_ff @(posedge clk) begin
    if (rst) begin
      decay_factor     <= DECAY_FACTOR_RST;
      drive_gain       <= DRIVE_GAIN_RST;
      fire_threshold   <= FIRE_THRESHOLD_RST;
      reset_potential  <= RESET_POTENTIAL_RST;
      refractory_ticks <= REFRACTORY_TICKS_RST;
      delay_ticks      <= DELAY_TICKS_RST;
      synaptic_weight  <= SYNAPTIC_WEIGHT_RST;
      integrate_enable <= 1'b1;
    end else if (cfg.valid) begin
      case (reg_idx_t'(cfg.index))
        REG_DECAY_FACTOR:     decay_factor     <= cfg.data[FACTOR_W-1:0];
        REG_DRIVE_GAIN:       drive_gain       <= cfg.data[FACTOR_W-1:0];
        REG_FIRE_THRESHOLD:   fire_threshold   <= cfg.data[POT_W-1:0];
        REG_RESET_POTENTIAL:  reset_potential  <= cfg.data[POT_W-1:0];
        REG_REFRACTORY_TICKS: refractory_ticks <= cfg.data[REFR_W-1:0];
        REG_DELAY_TICKS:      delay_ticks      <= cfg.data[DELAY_W-1:0];
        REG_SYNAPTIC_WEIGHT:  synaptic_weight  <= cfg.data[POT_W-1:0];
        REG_INTEGRATE_ENABLE: integrate_enable <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Target slot of a presynaptic spike: delay reduced modulo the ring depth,
  // then one compare-subtract on the sum with the pointer.
  logic [PTR_W-1:0] delay_mod;
  logic [PTR_W:0]   tgt_sum;
  logic [PTR_W-1:0] tgt;
  logic [PTR_W-1:0] ptr_inc;

  always_comb begin
    delay_mod = '0;
    for (int i = 0; i < (1 << DELAY_W); i++) begin
      if (delay_ticks == DELAY_W'(i)) begin
        delay_mod = PTR_W'(i % RING_DEPTH);
      end
    end
  end

  assign tgt_sum = {1'b0, ptr} + {1'b0, delay_mod};
  assign tgt     = (tgt_sum >= (PTR_W+1)'(RING_DEPTH)) ?
                   PTR_W'(tgt_sum - (PTR_W+1)'(RING_DEPTH)) : tgt_sum[PTR_W-1:0];
  assign ptr_inc = (ptr == PTR_W'(RING_DEPTH - 1)) ? '0 : ptr + 1'b1;

  // Tick computation.
  logic                     fired;
  pot_t                     base_pot;
  logic [REFR_W-1:0]        rc_eff;
  logic                     hold;
  logic signed [40:0]       leak_prod;
  logic signed [32:0]       drive_prod;
  pot_t                     leak;
  logic signed [CUR_W-1:0]  drive;
  pot_t                     integ_pot;
  pot_t                     slot_val;
  pot_t                     pot_next;
  logic [REFR_W-1:0]        refr_next;

  assign fired    = potential > fire_threshold;
  assign base_pot = fired ? reset_potential : potential;
  assign rc_eff   = fired ? '0 : refr_cnt;
  assign hold     = rc_eff < refractory_ticks;

  assign leak_prod  = base_pot * $signed({1'b0, decay_factor});
  assign drive_prod = cur_q * $signed({1'b0, drive_gain});
  assign leak       = leak_prod[39:16];
  assign drive      = drive_prod[31:16];

  assign integ_pot = integrate_enable ?
                     sat_pot({leak[POT_W-1], leak} + (POT_W+1)'(drive)) : base_pot;

  // A spike written this tick with a delay that wraps to zero lands in the current slot.
  always_comb begin
    if (pre_q && (tgt == ptr)) begin
      slot_val = synaptic_weight;
    end else if (slot_valid[ptr]) begin
      slot_val = byp_hit ? synaptic_weight : slot_rd;
    end else begin
      slot_val = '0;
    end
  end

  assign pot_next  = hold ? reset_potential :
                     sat_pot({integ_pot[POT_W-1], integ_pot} +
                             {slot_val[POT_W-1], slot_val});
  assign refr_next = (rc_eff == '1) ? rc_eff : rc_eff + 1'b1;

  // Ring memory: one write port, read of the slot the pointer will stand on next.
  logic [PTR_W-1:0] rd_addr;
  logic             wr_en;

  assign rd_addr = proc ? ptr_inc : ptr;
  assign wr_en   = proc && pre_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[tgt] <= synaptic_weight;
    end
    slot_rd <= slot_mem[rd_addr];
    byp_hit <= wr_en && (tgt == rd_addr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      potential  <= RESET_POTENTIAL_RST;
      refr_cnt   <= '0;
      ptr        <= '0;
      slot_valid <= '0;
    end else if (proc) begin
      potential <= pot_next;
      refr_cnt  <= refr_next;
      ptr       <= ptr_inc;
      if (pre_q) begin
        slot_valid[tgt] <= 1'b1;
      end
      // Consuming the current slot takes priority over a write to it.
      if (!hold) begin
        slot_valid[ptr] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (tick.valid && tick.ready) begin
        s1_valid <= 1'b1;
      end else if (proc) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      cur_q <= tick.input_current;
      pre_q <= tick.presyn_spike;
    end
    if (proc) begin
      out_spike <= fired;
      out_pot   <= pot_next;
    end
  end

  // The pointer moves only when a tick is processed.
  a_ptr_stable: assert property (@(posedge clk) disable iff (rst)
    $past(!rst && !proc) |-> $stable(ptr))
    else $error("ring pointer moved without a processed tick");

  // A consumed slot is empty afterwards, even if a spike was written to it.
  a_slot_cleared: assert property (@(posedge clk) disable iff (rst)
    $past(!rst && proc && !hold) |-> !slot_valid[$past(ptr)])
    else $error("consumed ring slot still valid");

  // During the refractory hold the potential sits at the reset potential.
  a_hold_pot: assert property (@(posedge clk) disable iff (rst)
    $past(!rst && proc && hold) |-> (potential == $past(reset_potential)))
    else $error("potential not held during refractory period");

endmodule

[verif/tb_lif_neuron_with_delay_ring_core.sv]
module tb_lif_neuron_with_delay_ring_core;
  import lifdr_pkg::*;

  localparam int RING_DEPTH  = 16;
  localparam int QUIET_LIMIT = 1000;
  localparam int LONG_HOLD   = 80;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_TICKS = 125;

  typedef struct packed {
    logic spike;
    pot_t pot;
  } neuron_out_t;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;
  typedef enum int {PROF_TYPICAL, PROF_WILD, PROF_EXTREME} cfg_profile_t;

  typedef struct {
    row_kind_t            kind;
    reg_idx_t             idx;
    logic [CFG_DAT_W-1:0] value;
    cur_t                 cur;
    logic                 pre;
    bit                   typed;
    logic                 spike;
    pot_t                 pot;
  } plan_row_t;

  logic clk;
  logic rst;

  lifdr_tick_if   tick_bus();
  lifdr_result_if result_bus();
  lifdr_cfg_if    cfg_bus();

  lif_neuron_with_delay_ring_core #(.RING_DEPTH(RING_DEPTH)) uut (
    .clk    (clk),
    .rst    (rst),
    .tick   (tick_bus),
    .result (result_bus),
    .cfg    (cfg_bus)
  );

  // Predictor copy of the configuration registers.
  logic [FACTOR_W-1:0] leak_factor;
  logic [FACTOR_W-1:0] gain;
  pot_t                thr;
  pot_t                rst_level;
  logic [REFR_W-1:0]   hold_len;
  logic [DELAY_W-1:0]  spike_delay;
  pot_t                syn_weight;
  logic                integ_on;

  // Predictor copy of the neuron state.
  pot_t              nrn_pot;
  logic [REFR_W-1:0] hold_count;
  int                ring_pos;
  pot_t              delay_ring [RING_DEPTH];

  neuron_out_t expected_out [$];
  int          errors;
  int          quiet;
  bit          steady;
  bit          tick_gaps;
  bit          result_gaps;
  bit          hold_results;

  plan_row_t directed_plan [32] = '{
    '{ROW_TICK, REG_DECAY_FACTOR, 24'd0, 16'sd0, 1'b1, 1'b1, 1'b0, -24'sd17920},
    '{ROW_TICK, REG_DECAY_FACTOR, 24'd0, 16'sd32767, 1'b0, 1'b1, 1'b0, -24'sd17920},
    '{ROW_TICK, REG_DECAY_FACTOR, 24'd0, 16'sh8000, 1'b0, 1'b1, 1'b0, -24'sd17920},
    '{ROW_TICK, REG_DECAY_FACTOR, 24'd0, 16'sd0, 1'b0, 1'b1, 1'b0, -24'sd17920},
    '{ROW_TICK, REG_DECAY_FACTOR, 24'd0, 16'sd32767, 1'b0, 1'b0, 1'b0, 24'sd0},
    '{ROW_TICK, REG_DECAY_FACTOR, 24'd0, 16'sh8000, 1'b1, 1'b0, 1'b0, 24'sd0},
    '{ROW_CFG, REG_REFRACTORY_TICKS, 24'd0, 16'sd0, 1'b0, 1'b0, 1'b0, 24'sd0},
    '{ROW_CFG, REG_DELAY_TICKS, 24'd0, 16'sd0, 1'b0, 1'b0, 1'b0, 24'sd0},
    '{ROW_TICK, REG_DECAY_FACTOR, 24'd0, 16'sd0, 1'b1, 1'b0, 1'b0, 24'sd0},
    '{ROW_CFG, REG_INTEGRATE_ENABLE, 24'd0, 16'sd0, 1'b0, 1'b0, 1'b0, 24'sd0},
    '{ROW_TICK, REG_DECAY_FACTOR, 24'd0, 16'sd12345, 1'b1, 1'b0, 1'b0, 24'sd0},
    '{ROW_CFG, REG_FIRE_THRESHOLD, POT_MIN, 16'sd0, 1'b0, 1'b0, 1'b0, 24'sd0},
    '{ROW_CFG, REG_RESET_POTENTIAL, POT_MAX, 16'sd0, 1'b0, 1'b0, 1'b0, 24'sd0},
    '{ROW_TICK, REG_DECAY_FACTOR, 24'd0, 16'sd0, 1'b0, 1'b0, 1'b0, 24'sd0},
    '{ROW_CFG, REG_INTEGRATE_ENABLE, 24'd1, 16'sd0, 1'b0, 1'b0, 1'b0, 24'sd0},
    '{ROW_CFG, REG_DECAY_FACTOR, 24'hFFFF, 16'sd0, 1'b0, 1'b0, 1'b0, 24'sd0},
    '{ROW_CFG, REG_DRIVE_GAIN, 24'hFFFF, 16'sd0, 1'b0, 1'b0, 1'b0, 24'sd0},
    '{ROW_CFG, REG_FIRE_THRESHOLD, POT_MAX, 16'sd0, 1'b0, 1'b0, 1'b0, 24'sd0},
    '{ROW_CFG, REG_RESET_POTENTIAL, POT_MIN, 16'sd0, 1'b0, 1'b0, 1'b0, 24'sd0},
    '{ROW_CFG, REG_REFRACTORY_TICKS, 24'd255, 16'sd0, 1'b0, 1'b0, 1'b0, 24'sd0},
    '{ROW_TICK, REG_DECAY_FACTOR, 24'd0, -16'sd1, 1'b0, 1'b1, 1'b0, POT_MIN},
    '{ROW_TICK, REG_DECAY_FACTOR, 24'd0, 16'sd32767, 1'b1, 1'b1, 1'b0, POT_MIN},
    '{ROW_CFG, REG_REFRACTORY_TICKS, 24'd0, 16'sd0, 1'b0, 1'b0, 1'b0, 24'sd0},
    '{ROW_CFG, REG_DECAY_FACTOR, 24'd0, 16'sd0, 1'b0, 1'b0, 1'b0, 24'sd0},
    '{ROW_TICK, REG_DECAY_FACTOR, 24'd0, 16'sd32767, 1'b0, 1'b0, 1'b0, 24'sd0},
    '{ROW_CFG, REG_DELAY_TICKS, 24'd1, 16'sd0, 1'b0, 1'b0, 1'b0, 24'sd0},
    '{ROW_CFG, REG_SYNAPTIC_WEIGHT, POT_MAX, 16'sd0, 1'b0, 1'b0, 1'b0, 24'sd0},
    '{ROW_TICK, REG_DECAY_FACTOR, 24'd0, 16'sh8000, 1'b1, 1'b0, 1'b0, 24'sd0},
    '{ROW_TICK, REG_DECAY_FACTOR, 24'd0, 16'sd0, 1'b0, 1'b0, 1'b0, 24'sd0},
    '{ROW_CFG, REG_SYNAPTIC_WEIGHT, POT_MIN, 16'sd0, 1'b0, 1'b0, 1'b0, 24'sd0},
    '{ROW_TICK, REG_DECAY_FACTOR, 24'd0, 16'sd0, 1'b1, 1'b0, 1'b0, 24'sd0},
    '{ROW_TICK, REG_DECAY_FACTOR, 24'd0, 16'sd0, 1'b0, 1'b0, 1'b0, 24'sd0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic pot_t clamp_pot(longint v);
    if (v > longint'(POT_MAX)) return POT_MAX;
    if (v < longint'(POT_MIN)) return POT_MIN;
    return pot_t'(v);
  endfunction

  // One tick of the neuron; updates the predictor state.
  function automatic neuron_out_t neuron_tick(cur_t cur, logic pre);
    int          slot;
    longint      leak;
    longint      drive;
    neuron_out_t r;
    slot = ring_pos;
    r.spike = 1'b0;
    // The spike write lands before the slot read, so a delay of zero is seen this tick.
    if (pre) delay_ring[(slot + int'(spike_delay)) % RING_DEPTH] = syn_weight;
    if (nrn_pot > thr) begin
      nrn_pot = rst_level;
      hold_count = '0;
      r.spike = 1'b1;
    end
    if (hold_count < hold_len) begin
      // The slot is left untouched during the hold.
      nrn_pot = rst_level;
    end else begin
      if (integ_on) begin
        leak = (longint'(nrn_pot) * longint'(leak_factor)) >>> 16;
        drive = (longint'(cur) * longint'(gain)) >>> 16;
        nrn_pot = clamp_pot(leak + drive);
      end
      nrn_pot = clamp_pot(longint'(nrn_pot) + longint'(delay_ring[slot]));
      delay_ring[slot] = '0;
    end
    ring_pos = (slot + 1) % RING_DEPTH;
    if (hold_count != '1) hold_count++;
    r.pot = nrn_pot;
    return r;
  endfunction

  function automatic void set_register(reg_idx_t idx, logic [CFG_DAT_W-1:0] v);
    case (idx)
      REG_DECAY_FACTOR:     leak_factor = v[FACTOR_W-1:0];
      REG_DRIVE_GAIN:       gain = v[FACTOR_W-1:0];
      REG_FIRE_THRESHOLD:   thr = v;
      REG_RESET_POTENTIAL:  rst_level = v;
      REG_REFRACTORY_TICKS: hold_len = v[REFR_W-1:0];
      REG_DELAY_TICKS:      spike_delay = v[DELAY_W-1:0];
      REG_SYNAPTIC_WEIGHT:  syn_weight = v;
      REG_INTEGRATE_ENABLE: integ_on = v[0];
      default: ;
    endcase
  endfunction

  task automatic send_tick(cur_t cur, logic pre, bit typed, neuron_out_t typed_out);
    neuron_out_t r;
    @(negedge clk);
    tick_bus.valid <= 1'b1;
    tick_bus.input_current <= cur;
    tick_bus.presyn_spike <= pre;
    @(posedge clk);
    while (!tick_bus.ready) @(posedge clk);
    r = neuron_tick(cur, pre);
    expected_out.insert(expected_out.size(), typed ? typed_out : r);
  endtask

  task automatic tick_gap(int n);
    @(negedge clk);
    tick_bus.valid <= 1'b0;
    tick_bus.input_current <= cur_t'($urandom);
    tick_bus.presyn_spike <= 1'($urandom);
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    tick_bus.valid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_DAT_W-1:0] v);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= v;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    set_register(idx, v);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // Result side: random back-pressure bursts, plus one long hold-off on request.
  initial begin
    result_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_results) begin
        hold_results = 1'b0;
        result_bus.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (!steady && result_gaps && $urandom_range(0, 9) == 0) begin
        result_bus.ready <= 1'b0;
        repeat ($urandom_range(0, 16)) @(negedge clk);
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    neuron_out_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (expected_out.size() == 0) begin
        errors++;
        $display("%0t: unexpected result spike_out %0b membrane_potential %0d", $time,
                 result_bus.spike_out, result_bus.membrane_potential);
      end else begin
        want = expected_out.pop_front();
        if (want.spike !== result_bus.spike_out) begin
          errors++;
          $display("%0t: spike_out expected %0b actual %0b", $time, want.spike,
                   result_bus.spike_out);
        end
        if (want.pot !== result_bus.membrane_potential) begin
          errors++;
          $display("%0t: membrane_potential expected %0d actual %0d", $time, want.pot,
                   result_bus.membrane_potential);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((tick_bus.valid && tick_bus.ready) || (result_bus.valid && result_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("lif_neuron_with_delay_ring_core test failed");
      $finish;
    end
  end

  initial begin
    int                   ph;
    int                   k;
    int                   t;
    cfg_profile_t         prof;
    logic [CFG_DAT_W-1:0] cfg_val [8];
    reg_idx_t             r;
    cur_t                 cur;
    logic                 pre;

    rst = 1'b1;
    tick_bus.valid = 1'b0;
    tick_bus.input_current = '0;
    tick_bus.presyn_spike = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = REG_DECAY_FACTOR;
    cfg_bus.data = '0;
    errors = 0;
    quiet = 0;
    steady = 1'b0;
    tick_gaps = 1'b1;
    result_gaps = 1'b1;
    hold_results = 1'b0;

    leak_factor = DECAY_FACTOR_RST;
    gain = DRIVE_GAIN_RST;
    thr = FIRE_THRESHOLD_RST;
    rst_level = RESET_POTENTIAL_RST;
    hold_len = REFRACTORY_TICKS_RST;
    spike_delay = DELAY_TICKS_RST;
    syn_weight = SYNAPTIC_WEIGHT_RST;
    integ_on = 1'b1;
    nrn_pot = RESET_POTENTIAL_RST;
    hold_count = '0;
    ring_pos = 0;
    foreach (delay_ring[i]) delay_ring[i] = '0;

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_CFG) begin
        drain();
        write_reg(directed_plan[i].idx, directed_plan[i].value);
      end else begin
        send_tick(directed_plan[i].cur, directed_plan[i].pre, directed_plan[i].typed,
                  {directed_plan[i].spike, directed_plan[i].pot});
      end
    end
    drain();

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == RAND_PHASES - 1 || ph % 2 == 0) prof = PROF_TYPICAL;
      else if (ph % 4 == 1) prof = PROF_WILD;
      else prof = PROF_EXTREME;

      case (prof)
        PROF_TYPICAL: begin
          cfg_val[REG_DECAY_FACTOR] = 24'($urandom_range(58000, 65535));
          cfg_val[REG_DRIVE_GAIN] = 24'($urandom_range(0, 65535));
          t = int'($urandom_range(0, 40000)) - 20000;
          cfg_val[REG_FIRE_THRESHOLD] = 24'(t);
          cfg_val[REG_RESET_POTENTIAL] = 24'(t - int'($urandom_range(0, 40000)));
          cfg_val[REG_REFRACTORY_TICKS] = 24'($urandom_range(0, 8));
          cfg_val[REG_DELAY_TICKS] = 24'($urandom_range(0, 15));
          cfg_val[REG_SYNAPTIC_WEIGHT] = 24'(int'($urandom_range(0, 20000)) - 10000);
          cfg_val[REG_INTEGRATE_ENABLE] = 24'($urandom_range(0, 3) != 0);
        end
        PROF_WILD: begin
          foreach (cfg_val[i]) cfg_val[i] = 24'($urandom);
        end
        default: begin
          cfg_val[REG_DECAY_FACTOR] = $urandom_range(0, 1) ? 24'hFFFF : 24'h0;
          cfg_val[REG_DRIVE_GAIN] = $urandom_range(0, 1) ? 24'hFFFF : 24'h0;
          cfg_val[REG_FIRE_THRESHOLD] = $urandom_range(0, 1) ? POT_MAX : POT_MIN;
          cfg_val[REG_RESET_POTENTIAL] = $urandom_range(0, 1) ? POT_MAX : POT_MIN;
          cfg_val[REG_REFRACTORY_TICKS] = $urandom_range(0, 1) ? 24'd255 : 24'd0;
          cfg_val[REG_DELAY_TICKS] = $urandom_range(0, 1) ? 24'd15 : 24'd0;
          cfg_val[REG_SYNAPTIC_WEIGHT] = $urandom_range(0, 1) ? POT_MAX : POT_MIN;
          cfg_val[REG_INTEGRATE_ENABLE] = 24'($urandom_range(0, 1));
        end
      endcase

      r = r.first();
      do begin
        write_reg(r, cfg_val[r]);
        r = r.next();
      end while (r != r.first());

      steady = (ph == RAND_PHASES - 1);
      tick_gaps = ($urandom_range(0, 3) != 0);
      result_gaps = ($urandom_range(0, 3) != 0);
      // Stall the result side long enough for the block to back up into the request side.
      if (ph == 2) hold_results = 1'b1;

      for (k = 0; k < PHASE_TICKS; k++) begin
        if (!steady && tick_gaps && $urandom_range(0, 9) == 0) tick_gap($urandom_range(1, 17));
        if (prof == PROF_TYPICAL && $urandom_range(0, 1) == 1)
          cur = cur_t'($urandom_range(0, 32767));
        else
          cur = cur_t'($urandom);
        pre = ($urandom_range(0, 2) == 0);
        send_tick(cur, pre, 1'b0, '0);
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("lif_neuron_with_delay_ring_core test passed");
    end else begin
      $display("lif_neuron_with_delay_ring_core test failed");
    end
    $finish;
  end

endmodule
